[rtl/core/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, constants and helpers for the glyph bitmap classifier.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned RowsN    = 16;
  localparam int unsigned ColsN    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // arm region column masks, MSB is column 0
  localparam logic [7:0] ArmVertMask  = 8'h3C;
  localparam logic [7:0] ArmLeftMask  = 8'hE0;
  localparam logic [7:0] ArmRightMask = 8'h07;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFullMin  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHorizMin = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVertMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDotMax   = 3'd3;

  localparam logic [7:0] FullMinRst  = 8'd45;
  localparam logic [3:0] HorizMinRst = 4'd5;
  localparam logic [4:0] VertMinRst  = 5'd6;
  localparam logic [7:0] DotMaxRst   = 8'd4;

  typedef enum logic [3:0] {
    ClsBlank     = 4'd0,
    ClsFull      = 4'd1,
    ClsCross     = 4'd2,
    ClsTeeRight  = 4'd3,
    ClsTeeLeft   = 4'd4,
    ClsTeeDown   = 4'd5,
    ClsTeeUp     = 4'd6,
    ClsCornerDR  = 4'd7,
    ClsCornerDL  = 4'd8,
    ClsCornerUR  = 4'd9,
    ClsCornerUL  = 4'd10,
    ClsHoriz     = 4'd11,
    ClsVert      = 4'd12,
    ClsDot       = 4'd13,
    ClsShade     = 4'd14
  } shape_t;

  typedef struct packed {
    logic [7:0] full_min;
    logic [3:0] horiz_min;
    logic [4:0] vert_min;
    logic [7:0] dot_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] total;     // 0..128
    logic [3:0] max_row;   // 0..8
    logic [4:0] max_col;   // 0..16
    logic       arm_top;
    logic       arm_bot;
    logic       arm_left;
    logic       arm_right;
  } feat_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

endpackage

[rtl/core/gbc_feat.sv]
// ----------------------------------------------------------------------------
// gbc_feat
// Pixel count, widest row, tallest column and arm region hits of one glyph.
// ----------------------------------------------------------------------------
module gbc_feat
  import gbc_pkg::*;
(
  input  logic [63:0] rows_top,
  input  logic [63:0] rows_bottom,
  output feat_t       feat
);

  logic [7:0] rows    [RowsN];
  logic [3:0] row_w   [RowsN];
  logic [4:0] col_cnt [ColsN];
  logic [3:0] rmax8   [8];
  logic [3:0] rmax4   [4];
  logic [3:0] rmax2   [2];
  logic [4:0] cmax4   [4];
  logic [4:0] cmax2   [2];
  logic [5:0] csum4   [4];
  logic [6:0] csum2   [2];
  logic       hit_t, hit_b, hit_l, hit_r;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      rows[r]     = rows_top[8*(7-r) +: 8];
      rows[r + 8] = rows_bottom[8*(7-r) +: 8];
    end
    for (int r = 0; r < RowsN; r++) begin
      row_w[r] = popcount8(rows[r]);
    end
    for (int c = 0; c < ColsN; c++) begin
      col_cnt[c] = {1'b0, popcount8({rows[0][7-c], rows[1][7-c], rows[2][7-c],
                                     rows[3][7-c], rows[4][7-c], rows[5][7-c],
                                     rows[6][7-c], rows[7][7-c]})}
                 + {1'b0, popcount8({rows[8][7-c], rows[9][7-c], rows[10][7-c],
                                     rows[11][7-c], rows[12][7-c], rows[13][7-c],
                                     rows[14][7-c], rows[15][7-c]})};
    end

    // max and sum trees
    for (int i = 0; i < 8; i++) begin
      rmax8[i] = (row_w[2*i] > row_w[2*i+1]) ? row_w[2*i] : row_w[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      rmax4[i] = (rmax8[2*i] > rmax8[2*i+1]) ? rmax8[2*i] : rmax8[2*i+1];
      cmax4[i] = (col_cnt[2*i] > col_cnt[2*i+1]) ? col_cnt[2*i] : col_cnt[2*i+1];
      csum4[i] = {1'b0, col_cnt[2*i]} + {1'b0, col_cnt[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      rmax2[i] = (rmax4[2*i] > rmax4[2*i+1]) ? rmax4[2*i] : rmax4[2*i+1];
      cmax2[i] = (cmax4[2*i] > cmax4[2*i+1]) ? cmax4[2*i] : cmax4[2*i+1];
      csum2[i] = {1'b0, csum4[2*i]} + {1'b0, csum4[2*i+1]};
    end

    hit_t = 1'b0;
    hit_b = 1'b0;
    hit_l = 1'b0;
    hit_r = 1'b0;
    for (int r = 0; r <= 6; r++) begin
      hit_t = hit_t | (|(rows[r] & ArmVertMask));
      hit_b = hit_b | (|(rows[r + 9] & ArmVertMask));
      hit_l = hit_l | (|(rows[r + 5] & ArmLeftMask));
      hit_r = hit_r | (|(rows[r + 5] & ArmRightMask));
    end

    feat.total     = {1'b0, csum2[0]} + {1'b0, csum2[1]};
    feat.max_row   = (rmax2[0] > rmax2[1]) ? rmax2[0] : rmax2[1];
    feat.max_col   = (cmax2[0] > cmax2[1]) ? cmax2[0] : cmax2[1];
    feat.arm_top   = hit_t;
    feat.arm_bot   = hit_b;
    feat.arm_left  = hit_l;
    feat.arm_right = hit_r;
  end

endmodule

[rtl/core/gbc_classify.sv]
// ----------------------------------------------------------------------------
// gbc_classify
// Fixed-priority shape decision from registered features and thresholds.
// ----------------------------------------------------------------------------
module gbc_classify
  import gbc_pkg::*;
(
  input  feat_t  feat,
  input  cfg_t   cfg,
  output shape_t cls
);

  logic t, b, l, r;

  always_comb begin
    t = feat.arm_top;
    b = feat.arm_bot;
    l = feat.arm_left;
    r = feat.arm_right;
    // empty glyph wins even over a zero full-block threshold
    if (feat.total == '0)                 cls = ClsBlank;
    else if (feat.total >= cfg.full_min)  cls = ClsFull;
    else if (t && b && l && r)            cls = ClsCross;
    else if (t && b && r && !l)           cls = ClsTeeRight;
    else if (t && b && l && !r)           cls = ClsTeeLeft;
    else if (b && l && r && !t)           cls = ClsTeeDown;
    else if (t && l && r && !b)           cls = ClsTeeUp;
    else if (b && r && !t && !l)          cls = ClsCornerDR;
    else if (b && l && !t && !r)          cls = ClsCornerDL;
    else if (t && r && !b && !l)          cls = ClsCornerUR;
    else if (t && l && !b && !r)          cls = ClsCornerUL;
    else if (feat.max_row >= cfg.horiz_min) cls = ClsHoriz;
    else if (feat.max_col >= cfg.vert_min)  cls = ClsVert;
    else if (feat.total <= cfg.dot_max)     cls = ClsDot;
    else                                    cls = ClsShade;
  end

endmodule

[rtl/core/glyph_bitmap_classifier_unit.sv]
// A beat accepted into the input register moves to the feature register, then
// the result register; one glyph per cycle while out_stall is low. The feature
// stage (popcount, max trees) and the priority compare sit between registers.
// Each stage holds only while the one after it is full and stalled.
// Reset (rst, synchronous) empties all stages and loads default thresholds.
// ----------------------------------------------------------------------------
// glyph_bitmap_classifier_unit
// Input register, feature register and result register around the
// feature extraction and classification logic.
// ----------------------------------------------------------------------------
module glyph_bitmap_classifier_unit
  import gbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         rows_top,
  input  logic [63:0]         rows_bottom,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          shape_class,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t        cfg;
  logic        in_vld;
  logic [63:0] top_q, bot_q;
  logic        feat_vld;
  feat_t       feat_d, feat_q;
  shape_t      cls_d;
  logic        out_ready, feat_ready, in_ready;

  assign out_ready  = !out_valid || !out_stall;
  assign feat_ready = !feat_vld || out_ready;
  assign in_ready   = !in_vld || feat_ready;
  assign in_stall   = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_min  <= FullMinRst;
      cfg.horiz_min <= HorizMinRst;
      cfg.vert_min  <= VertMinRst;
      cfg.dot_max   <= DotMaxRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegFullMin:  cfg.full_min  <= cfg_data;
        RegHorizMin: cfg.horiz_min <= cfg_data[3:0];
        RegVertMin:  cfg.vert_min  <= cfg_data[4:0];
        RegDotMax:   cfg.dot_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      feat_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready)   in_vld    <= in_valid;
      if (feat_ready) feat_vld  <= in_vld;
      if (out_ready)  out_valid <= feat_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      top_q <= rows_top;
      bot_q <= rows_bottom;
    end
    if (feat_ready && in_vld) feat_q <= feat_d;
    if (out_ready && feat_vld) shape_class <= cls_d;
  end

  gbc_feat u_feat (
    .rows_top    (top_q),
    .rows_bottom (bot_q),
    .feat        (feat_d)
  );

  gbc_classify u_classify (
    .feat (feat_q),
    .cfg  (cfg),
    .cls  (cls_d)
  );

endmodule

[rtl/core/gbc_checker.sv]
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level checks for the glyph bitmap classifier, bound to the top level.
// ----------------------------------------------------------------------------
module gbc_checker
  import gbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] shape_class
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shape_class))
    else $error("stalled result beat changed");

  // reset empties the pipe
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // with the result register empty nothing upstream can be blocked
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // only defined class codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shape_class <= ClsShade)
    else $error("undefined shape class");

endmodule

bind glyph_bitmap_classifier_unit gbc_checker u_gbc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .shape_class (shape_class)
);

[tb/sv/glyph_bitmap_classifier_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_bitmap_classifier_unit_tb
// Drives 16x8 glyph bitmaps through the classifier and checks each shape class
// against an in-bench predictor that tracks the threshold registers. Covers
// hand-built junctions, corners, lines, dots and shades, then shaped random
// glyphs under default, extreme and random thresholds with bursty input and
// a stalling receiver.
// ----------------------------------------------------------------------------
module glyph_bitmap_classifier_unit_tb;
  import gbc_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [63:0]         rows_top = '0;
  logic [63:0]         rows_bottom = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          shape_class;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  glyph_bitmap_classifier_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rows_top    (rows_top),
    .rows_bottom (rows_bottom),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .shape_class (shape_class),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // bench copy of the threshold registers
  cfg_t   thresholds = '{full_min: FullMinRst, horiz_min: HorizMinRst,
                         vert_min: VertMinRst, dot_max: DotMaxRst};
  shape_t pending_classes[$];
  int     errors = 0;
  int     cycles = 0;

  // sender and receiver pacing
  bit     gaps_on = 1'b0;
  int     burst_left = 0;
  int     stall_mode = 0;
  int     stall_run = 0;
  logic   stall_hold = 1'b0;

  function automatic shape_t classify_glyph(input logic [63:0] top,
                                            input logic [63:0] bot);
    logic [7:0] row_bits [16];
    int         col_height [8];
    int         total, widest, tallest, w, r, c;
    logic       up, down, left, right;
    total = 0;
    widest = 0;
    tallest = 0;
    up = 1'b0;
    down = 1'b0;
    left = 1'b0;
    right = 1'b0;
    for (c = 0; c < 8; c++) col_height[c] = 0;
    for (r = 0; r < 16; r++) begin
      row_bits[r] = (r < 8) ? top[63-8*r -: 8] : bot[63-8*(r-8) -: 8];
      w = $countones(row_bits[r]);
      total += w;
      if (w > widest) widest = w;
      for (c = 0; c < 8; c++) col_height[c] += int'(row_bits[r][7-c]);
      if (r <= 6 && |(row_bits[r] & ArmVertMask)) up = 1'b1;
      if (r >= 9 && |(row_bits[r] & ArmVertMask)) down = 1'b1;
      if (r >= 5 && r <= 11) begin
        if (|(row_bits[r] & ArmLeftMask)) left = 1'b1;
        if (|(row_bits[r] & ArmRightMask)) right = 1'b1;
      end
    end
    for (c = 0; c < 8; c++) if (col_height[c] > tallest) tallest = col_height[c];

    if (total == 0) return ClsBlank;
    if (total >= thresholds.full_min) return ClsFull;
    if (up && down && left && right) return ClsCross;
    if (up && down && right && !left) return ClsTeeRight;
    if (up && down && left && !right) return ClsTeeLeft;
    if (down && left && right && !up) return ClsTeeDown;
    if (up && left && right && !down) return ClsTeeUp;
    if (down && right && !up && !left) return ClsCornerDR;
    if (down && left && !up && !right) return ClsCornerDL;
    if (up && right && !down && !left) return ClsCornerUR;
    if (up && left && !down && !right) return ClsCornerUL;
    if (widest >= thresholds.horiz_min) return ClsHoriz;
    if (tallest >= thresholds.vert_min) return ClsVert;
    if (total <= thresholds.dot_max) return ClsDot;
    return ClsShade;
  endfunction

  // shaped random glyph: mostly line art, some sparse noise and extremes
  function automatic void make_glyph(output logic [63:0] top,
                                     output logic [63:0] bot);
    logic [7:0] g [16];
    logic [7:0] cm, m;
    logic [3:0] arms;
    int         kind, r, c, r0, h, s, len, wd, d, n;
    kind = $urandom_range(0, 11);
    for (r = 0; r < 16; r++) g[r] = '0;
    case (kind)
      0: begin
        d = $urandom_range(1, 5);
        for (r = 0; r < 16; r++) begin
          g[r] = 8'hFF;
          for (n = 0; n < d; n++) g[r] &= 8'($urandom);
        end
      end
      1, 2, 3, 4, 5, 6: begin
        arms = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 5))
          0: cm = 8'h18;
          1: cm = 8'h10;
          2: cm = 8'h08;
          3: cm = 8'h3C;
          4: cm = 8'h20;
          default: cm = 8'h04;
        endcase
        r0 = $urandom_range(6, 9);
        h = $urandom_range(1, 2);
        if (arms[3]) for (r = 0; r <= r0; r++) g[r] |= cm;
        if (arms[2]) for (r = r0; r < 16; r++) g[r] |= cm;
        for (r = r0; r < r0 + h; r++) begin
          if (arms[1]) g[r] |= 8'hF0;
          if (arms[0]) g[r] |= 8'h0F;
        end
        if ($urandom_range(0, 2) == 0) g[$urandom_range(0, 15)][$urandom_range(0, 7)] = 1'b1;
      end
      7: begin
        for (n = 0; n < $urandom_range(1, 2); n++) begin
          wd = $urandom_range(1, 8);
          m = 8'hFF << (8 - wd);
          m = m >> $urandom_range(0, 8 - wd);
          g[$urandom_range(0, 15)] = m;
        end
      end
      8: begin
        c = $urandom_range(0, 7);
        s = $urandom_range(0, 15);
        len = $urandom_range(1, 16 - s);
        for (r = s; r < s + len; r++) g[r][7-c] = 1'b1;
      end
      9: begin
        for (n = 0; n < $urandom_range(1, 6); n++)
          g[$urandom_range(0, 15)][$urandom_range(0, 7)] = 1'b1;
      end
      10: begin
        for (r = 0; r < 16; r++) g[r] = 8'($urandom) | 8'($urandom);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: ;
          1: for (r = 0; r < 16; r++) g[r] = 8'hFF;
          default: g[$urandom_range(0, 15)][$urandom_range(0, 7)] = 1'b1;
        endcase
      end
    endcase
    for (r = 0; r < 16; r++) begin
      if (r < 8) top[63-8*r -: 8] = g[r];
      else bot[63-8*(r-8) -: 8] = g[r];
    end
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run = $urandom_range(1, 8);
        end
        stall_run--;
        out_stall <= stall_hold;
      end
    endcase
  end

  // record accepted beats and check results, both on pre-edge values
  always @(posedge clk) begin : check_results
    shape_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_classes.size() == 0) begin
        errors++;
        $display("%0t: class beat with nothing expected, expected none, actual %0d",
                 $time, shape_class);
      end else begin
        want = pending_classes.pop_front();
        if (shape_class !== want) begin
          errors++;
          $display("%0t: shape_class mismatch, expected %0d (%s), actual %0d",
                   $time, want, want.name(), shape_class);
        end
      end
    end
    if (!rst && in_valid && !in_stall)
      pending_classes.push_back(classify_glyph(rows_top, rows_bottom));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d classes outstanding", $time, pending_classes.size());
      $display("glyph_bitmap_classifier_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_glyph(input logic [63:0] top, input logic [63:0] bot);
    @(negedge clk);
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid    <= 1'b1;
    rows_top    <= top;
    rows_bottom <= bot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      RegFullMin:  thresholds.full_min  = val;
      RegHorizMin: thresholds.horiz_min = val[3:0];
      RegVertMin:  thresholds.vert_min  = val[4:0];
      RegDotMax:   thresholds.dot_max   = val;
      default: ;  // unmapped index, ignored
    endcase
  endtask

  task automatic send_random(input int count);
    logic [63:0] top, bot;
    repeat (count) begin
      make_glyph(top, bot);
      send_glyph(top, bot);
    end
  endtask

  // raw register image; upper bits of the narrow registers carry junk
  task automatic set_thresholds(input logic [7:0] full_min, input logic [3:0] horiz,
                                input logic [4:0] vert, input logic [7:0] dot_max);
    write_reg(CfgIdxW'($urandom_range(4, 7)), 8'($urandom));
    write_reg(RegFullMin, full_min);
    write_reg(RegHorizMin, {4'($urandom), horiz});
    write_reg(RegVertMin, {3'($urandom), vert});
    write_reg(RegDotMax, dot_max);
  endtask

  task automatic test_directed_shapes;
    gaps_on = 1'b0;
    stall_mode = 1;
    send_glyph(64'h0, 64'h0);                                   // blank
    send_glyph(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);   // full
    send_glyph(64'h18181818_181818FF, 64'hFF181818_18181818);   // cross
    send_glyph(64'h18181818_1818181F, 64'h1F181818_18181818);   // tee right
    send_glyph(64'h18181818_181818F8, 64'hF8181818_18181818);   // tee left
    send_glyph(64'h00000000_000000FF, 64'hFF181818_18181818);   // tee down
    send_glyph(64'h18181818_181818FF, 64'hFF000000_00000000);   // tee up
    send_glyph(64'h00000000_0000001F, 64'h1F181818_18181818);   // corner down-right
    send_glyph(64'h00000000_000000F8, 64'hF8181818_18181818);   // corner down-left
    send_glyph(64'h18181818_1818181F, 64'h1F000000_00000000);   // corner up-right
    send_glyph(64'h18181818_181818F8, 64'hF8000000_00000000);   // corner up-left
    send_glyph(64'h00000000_000000FF, 64'hFF000000_00000000);   // horizontal
    send_glyph(64'h80808080_80000000, 64'h00000000_80808080);   // vertical, no arms
    send_glyph(64'h18181818_18181818, 64'h18181818_18181818);   // top and bottom only
    send_glyph(64'h80000000_00000000, 64'h0);                   // dot, first pixel
    send_glyph(64'h0, 64'h00000000_00000001);                   // dot, last pixel
    send_glyph(64'h81008100_00000000, 64'h00000000_81008100);   // shade
    send_glyph(64'hFFFFFFFF_FFF80000, 64'h0);                   // count on full threshold
    send_glyph(64'hFFFFFFFF_FFF00000, 64'h0);                   // one below it
    send_glyph(64'h80808080_00000000, 64'h0);                   // count on dot limit
    send_glyph(64'h80808080_80000000, 64'h0);                   // one above it
    send_glyph(64'hAAAAAAAA_AAAAAAAA, 64'h55555555_55555555);
    send_glyph(64'h55555555_55555555, 64'hAAAAAAAA_AAAAAAAA);
    drain_results();
  endtask

  task automatic test_random_default;
    gaps_on = 1'b1;
    stall_mode = 1;
    send_random(500);
    drain_results();
  endtask

  task automatic test_back_to_back;
    gaps_on = 1'b0;
    stall_mode = 0;
    send_random(150);
    drain_results();
  endtask

  task automatic test_threshold_extremes;
    int i;
    for (i = 0; i < 6; i++) begin
      case (i)
        0: set_thresholds(8'd0, 4'd0, 5'd0, 8'd0);
        1: set_thresholds(8'd128, 4'd8, 5'd16, 8'd128);
        2: set_thresholds(8'd255, 4'd15, 5'd31, 8'd255);
        3: set_thresholds(8'd129, 4'd9, 5'd17, 8'd0);
        4: set_thresholds(8'd1, 4'd1, 5'd1, 8'd1);
        default: set_thresholds(FullMinRst, HorizMinRst, VertMinRst, DotMaxRst);
      endcase
      gaps_on = i[0];
      stall_mode = i % 3;
      // blank must win even over a zero full threshold
      send_glyph(64'h0, 64'h0);
      send_glyph(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
      send_random(130);
      drain_results();
    end
  endtask

  task automatic test_random_thresholds;
    repeat (3) begin
      set_thresholds(8'($urandom_range(0, 255)), 4'($urandom), 5'($urandom),
                     8'($urandom_range(0, 255)));
      gaps_on = 1'($urandom_range(0, 1));
      stall_mode = $urandom_range(0, 2);
      send_random(70);
      drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_shapes();
    test_random_default();
    test_back_to_back();
    test_threshold_extremes();
    test_random_thresholds();
    if (errors == 0) begin
      $display("glyph_bitmap_classifier_unit_tb: done, clean");
    end else begin
      $display("glyph_bitmap_classifier_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gbc_pkg.sv
rtl/core/gbc_feat.sv
rtl/core/gbc_classify.sv
rtl/core/glyph_bitmap_classifier_unit.sv
rtl/core/gbc_checker.sv
tb/sv/glyph_bitmap_classifier_unit_tb.sv
